// File: rtl/core/pkbs_pkg.sv
// Shared codes and constants for the pad keyed byte block shuffle unit.
package pkbs_pkg;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned ADDR_W      = 8;
  localparam int unsigned COUNT_W     = 9;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

endpackage

// File: rtl/core/pkbs_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pkbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/pad_keyed_byte_block_shuffle_unit.sv
// Top level of the pad keyed byte block shuffle unit.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: a load
//   (data byte, pad byte, end of stream) or a read. Every request yields
//   exactly one result on the output channel (out_valid / out_stall).
//   Loads fill a block; it closes at BLOCK_SIZE bytes (at most 256) or on
//   end_of_stream, and is then permuted in place by swaps keyed by the pad.
//   cfg_direction selects forward shuffle (0) or reverse unshuffle (1); it
//   is sampled when a block closes. cfg_ready is always high.
// Timing:
//   A load or a refused request gives its result in the cycle after accept.
//   A valid read first does one block RAM read, then state S_RD registers the result.
//   After a block of n bytes closes, the shared modulo/swap sequencer runs
//   once per position (key read, 8-step restoring modulo, two reads,
//   two writes), and in_stall is high while it runs.
// Stall and reset:
//   A request is taken only while the sequencer is idle and the output
//   register is free or being drained; a stalled result holds.
//   Reset empties the block, clears pending output and sets direction 0.
module pad_keyed_byte_block_shuffle_unit
  import pkbs_pkg::*;
#(
  parameter int unsigned BLOCK_SIZE = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_pad_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_block_last,
  output logic [1:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_direction
);

  localparam int unsigned LIMIT = (BLOCK_SIZE > STORE_DEPTH) ? STORE_DEPTH : BLOCK_SIZE;
  localparam logic [COUNT_W-1:0] LIMIT_C = COUNT_W'(LIMIT);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_KEY, S_KLOAD, S_MOD, S_RDI, S_RDJ, S_WRI, S_WRJ
  } state_t;

  state_t state_r, state_nxt;
  logic [COUNT_W-1:0] fill_r, fill_nxt;
  logic [COUNT_W-1:0] rp_r, rp_nxt;
  logic               pend_r, pend_nxt;
  logic               cfg_dir_r;
  logic               dir_r, dir_nxt;
  logic [ADDR_W-1:0]  i_r, i_nxt;
  logic [7:0]         quo_r, quo_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [7:0]         bi_r, bi_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  logic               accept;
  logic [COUNT_W-1:0] fill_inc;
  logic [COUNT_W-1:0] rp_inc;
  logic [COUNT_W:0]   rem_sh;
  logic [COUNT_W:0]   rem_step;
  logic               step_last;

  logic              blk_we, key_we;
  logic [ADDR_W-1:0] blk_waddr, blk_raddr, key_raddr;
  logic [7:0]        blk_wdata, blk_rdata, key_rdata;

  pkbs_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (blk_raddr),
    .rdata (blk_rdata)
  );

  pkbs_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (fill_r[ADDR_W-1:0]),
    .wdata (in_pad_byte),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  assign in_stall       = !((state_r == S_IDLE) && (!out_valid_r || !out_stall));
  assign accept         = in_valid && !in_stall;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_block_last = out_last_r;
  assign out_status     = out_status_r;

  assign fill_inc  = fill_r + COUNT_W'(1);
  assign rp_inc    = rp_r + COUNT_W'(1);
  assign rem_sh    = {rem_r, quo_r[7]};
  assign rem_step  = (rem_sh >= {1'b0, fill_r}) ? (rem_sh - {1'b0, fill_r}) : rem_sh;
  assign step_last = dir_r ? (i_r == '0) : ({1'b0, i_r} == (fill_r - COUNT_W'(1)));

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    rp_nxt         = rp_r;
    pend_nxt       = pend_r;
    dir_nxt        = dir_r;
    i_nxt          = i_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    bi_nxt         = bi_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    blk_we         = 1'b0;
    key_we         = 1'b0;
    blk_waddr      = fill_r[ADDR_W-1:0];
    blk_wdata      = in_data_byte;
    blk_raddr      = i_r;
    key_raddr      = i_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_LOAD) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = '0;
            out_last_nxt  = 1'b0;
            if (pend_r) begin
              out_status_nxt = ST_BUSY;
            end else begin
              out_status_nxt = ST_OK;
              blk_we         = 1'b1;
              key_we         = 1'b1;
              fill_nxt       = fill_inc;
              if ((fill_inc >= LIMIT_C) || in_end_of_stream) begin
                dir_nxt   = cfg_dir_r;
                pend_nxt  = 1'b1;
                rp_nxt    = '0;
                i_nxt     = cfg_dir_r ? fill_r[ADDR_W-1:0] : '0;
                state_nxt = S_KEY;
              end
            end
          end else if (!pend_r) begin
            out_valid_nxt  = 1'b1;
            out_byte_nxt   = '0;
            out_last_nxt   = 1'b0;
            out_status_nxt = ST_EMPTY;
          end else begin
            blk_raddr = rp_r[ADDR_W-1:0];
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        out_valid_nxt  = 1'b1;
        out_byte_nxt   = blk_rdata;
        out_status_nxt = ST_OK;
        if (rp_inc >= fill_r) begin
          out_last_nxt = 1'b1;
          pend_nxt     = 1'b0;
          fill_nxt     = '0;
          rp_nxt       = '0;
        end else begin
          out_last_nxt = 1'b0;
          rp_nxt       = rp_inc;
        end
        state_nxt = S_IDLE;
      end
      S_KEY: begin
        state_nxt = S_KLOAD;
      end
      S_KLOAD: begin
        quo_nxt   = key_rdata;
        rem_nxt   = '0;
        cnt_nxt   = 3'd7;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        rem_nxt = rem_step[COUNT_W-1:0];
        quo_nxt = {quo_r[6:0], 1'b0};
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          state_nxt = S_RDI;
        end
      end
      S_RDI: begin
        state_nxt = S_RDJ;
      end
      S_RDJ: begin
        blk_raddr = rem_r[ADDR_W-1:0];
        bi_nxt    = blk_rdata;
        state_nxt = S_WRI;
      end
      S_WRI: begin
        blk_we    = 1'b1;
        blk_waddr = i_r;
        blk_wdata = blk_rdata;
        state_nxt = S_WRJ;
      end
      S_WRJ: begin
        blk_we    = 1'b1;
        blk_waddr = rem_r[ADDR_W-1:0];
        blk_wdata = bi_r;
        if (step_last) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = dir_r ? (i_r - ADDR_W'(1)) : (i_r + ADDR_W'(1));
          state_nxt = S_KEY;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      rp_r        <= '0;
      pend_r      <= 1'b0;
      cfg_dir_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rp_r        <= rp_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_dir_r <= cfg_direction;
      end
    end
    dir_r        <= dir_nxt;
    i_r          <= i_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    bi_r         <= bi_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// File: rtl/core/pkbs_checker.sv
// Port level checks for the pad keyed byte block shuffle unit.
module pkbs_checker
  import pkbs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_block_last,
  input logic [1:0] out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_status)
      && $stable(out_block_last))
    else $error("stalled result changed");

  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_last |-> out_status == ST_OK)
    else $error("block end flagged on refused request");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_byte == 8'd0 && !out_block_last)
    else $error("refused request carries data");

  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while result register blocked");

  a_request_answered: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##[0:1] out_valid)
    else $error("accepted request gave no result");

endmodule

bind pad_keyed_byte_block_shuffle_unit pkbs_checker u_pkbs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_block_last (out_block_last),
  .out_status     (out_status)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pad keyed byte block shuffle unit.
module testbench;
  import pkbs_pkg::*;

  localparam int unsigned BLOCK_SIZE  = 256;
  localparam int unsigned BLK_LIMIT   = (BLOCK_SIZE > STORE_DEPTH) ? STORE_DEPTH : BLOCK_SIZE;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic [7:0] pad;
    logic       eos;
  } shuf_req_t;

  typedef struct packed {
    logic [7:0] obyte;
    logic       last;
    logic [1:0] status;
  } shuf_rsp_t;

  typedef enum {RX_FREE, RX_COIN, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_stall;
  logic       in_opcode        = OP_LOAD;
  logic [7:0] in_data_byte     = '0;
  logic [7:0] in_pad_byte      = '0;
  logic       in_end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_stall        = 1'b0;
  logic [7:0] out_byte;
  logic       out_block_last;
  logic [1:0] out_status;
  logic       cfg_valid        = 1'b0;
  logic       cfg_ready;
  logic       cfg_direction    = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pad_keyed_byte_block_shuffle_unit #(
    .BLOCK_SIZE(BLOCK_SIZE)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_data_byte    (in_data_byte),
    .in_pad_byte     (in_pad_byte),
    .in_end_of_stream(in_end_of_stream),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_block_last  (out_block_last),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_direction   (cfg_direction)
  );

  // shadow copy of the unit
  logic [7:0]         blk_data [STORE_DEPTH];
  logic [7:0]         blk_key  [STORE_DEPTH];
  logic [COUNT_W-1:0] blk_fill    = '0;
  logic [COUNT_W-1:0] blk_rptr    = '0;
  logic               blk_pending = 1'b0;
  logic               shuf_dir    = 1'b0;

  shuf_req_t   req_backlog[$];
  shuf_rsp_t   shuffle_rsp_q[$];
  int unsigned n_queued = 0, n_taken = 0, n_results = 0, n_err = 0;
  int unsigned n_load = 0, n_busy = 0, n_read = 0, n_idle_rd = 0;
  int unsigned n_fwd = 0, n_rev = 0, n_max = 0;
  int unsigned hold_cmd = 0, hold_ack = 0, hold_left = 0;
  int unsigned burst_left = 0, gap_left = 0, mode_left = 0, rx_tick = 0;
  rx_mode_t    rx_mode = RX_FREE;
  bit          in_fire = 1'b0;
  shuf_req_t   cur_req;

  task automatic shuffle_block(input logic [COUNT_W-1:0] n);
    logic [7:0]         t;
    logic [COUNT_W-1:0] j;
    int                 i;
    for (int k = 0; k < n; k++) begin
      i = shuf_dir ? (n - 1 - k) : k;
      j = blk_key[i] % n;
      t = blk_data[i];
      blk_data[i] = blk_data[j[7:0]];
      blk_data[j[7:0]] = t;
    end
    if (shuf_dir) n_rev++;
    else n_fwd++;
    if (n > n_max) n_max = n;
  endtask

  task automatic shuffle_predict(input shuf_req_t r, output shuf_rsp_t rsp);
    rsp = '0;
    if (r.op == OP_LOAD) begin
      if (blk_pending) begin
        rsp.status = ST_BUSY;
        n_busy++;
      end else begin
        n_load++;
        if (blk_fill < STORE_DEPTH) begin
          blk_data[blk_fill[7:0]] = r.data;
          blk_key[blk_fill[7:0]]  = r.pad;
          blk_fill++;
        end
        if (blk_fill >= BLK_LIMIT || r.eos) begin
          shuffle_block(blk_fill);
          blk_rptr    = '0;
          blk_pending = 1'b1;
        end
      end
    end else if (!blk_pending) begin
      rsp.status = ST_EMPTY;
      n_idle_rd++;
    end else begin
      rsp.status = ST_OK;
      rsp.obyte  = blk_data[blk_rptr[7:0]];
      blk_rptr++;
      n_read++;
      if (blk_rptr >= blk_fill) begin
        rsp.last    = 1'b1;
        blk_pending = 1'b0;
        blk_fill    = '0;
        blk_rptr    = '0;
      end
    end
  endtask

  function automatic void check_field(string fld, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      n_err++;
      if (n_err <= 50)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
    end
  endfunction

  function automatic void push_req(logic op, logic [7:0] d, logic [7:0] p, logic e);
    req_backlog.push_back('{op, d, p, e});
    n_queued++;
  endfunction

  // well-formed block: n loads closed by end of stream (or the size limit), then n reads; noisy mixes in stray requests
  function automatic void queue_block(int unsigned n, bit noisy);
    for (int unsigned k = 0; k < n; k++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        push_req(OP_READ, 8'($urandom), 8'($urandom), 1'($urandom));
      push_req(OP_LOAD, 8'($urandom), 8'($urandom), (k == n - 1) && (n < BLK_LIMIT));
    end
    for (int unsigned k = 0; k < n; k++) begin
      if (noisy && $urandom_range(0, 7) == 0)
        push_req(OP_LOAD, 8'($urandom), 8'($urandom), 1'($urandom));
      push_req(OP_READ, 8'($urandom), 8'($urandom), 1'($urandom));
    end
    if (noisy && $urandom_range(0, 3) == 0)
      push_req(OP_READ, 8'($urandom), 8'($urandom), 1'($urandom));
  endfunction

  function automatic void queue_noise(int unsigned cnt);
    for (int unsigned k = 0; k < cnt; k++)
      push_req(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
               $urandom_range(0, 3) == 0);
  endfunction

  function automatic void queue_edge_block();
    push_req(OP_LOAD, 8'h00, 8'hFF, 1'b0);
    push_req(OP_LOAD, 8'hFF, 8'h00, 1'b0);
    push_req(OP_LOAD, 8'h5A, 8'h81, 1'b0);
    push_req(OP_LOAD, 8'hA5, 8'h7E, 1'b1);
    for (int k = 0; k < 4; k++) push_req(OP_READ, 8'hFF, 8'hFF, 1'b1);
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (n_taken != n_queued || shuffle_rsp_q.size() != 0 || in_stall);
  endtask

  task automatic set_direction(input logic d);
    wait_drained();
    @(negedge clk);
    cfg_valid     <= 1'b1;
    cfg_direction <= d;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // request driver: bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_backlog.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        cur_req = req_backlog.pop_front();
        in_opcode        <= cur_req.op;
        in_data_byte     <= cur_req.data;
        in_pad_byte      <= cur_req.pad;
        in_end_of_stream <= cur_req.eos;
        in_valid         <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // result sink stall pattern
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_ack != hold_cmd) begin
        hold_ack  = hold_cmd;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      rx_tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:     out_stall <= 1'b0;
          RX_COIN:     out_stall <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_stall <= (rx_tick % 5) < 2;
          default:     out_stall <= $urandom_range(0, 3) != 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin : mon
    shuf_req_t acc;
    shuf_rsp_t want;
    in_fire = rst_n && in_valid && !in_stall;
    if (rst_n && cfg_valid && cfg_ready) shuf_dir = cfg_direction;
    if (in_fire) begin
      acc = '{in_opcode, in_data_byte, in_pad_byte, in_end_of_stream};
      shuffle_predict(acc, want);
      shuffle_rsp_q.push_back(want);
      n_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (shuffle_rsp_q.size() == 0) begin
        n_err++;
        if (n_err <= 50)
          $display({"%0t: result with nothing outstanding, expected none, ",
                    "actual byte %0h last %b status %0d"},
                   $time, out_byte, out_block_last, out_status);
      end else begin
        want = shuffle_rsp_q.pop_front();
        check_field("out_byte", want.obyte, out_byte);
        check_field("out_block_last", 8'(want.last), 8'(out_block_last));
        check_field("out_status", 8'(want.status), 8'(out_status));
      end
    end
  end

  initial begin
    int unsigned mark;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_direction(1'b0);
    push_req(OP_READ, 8'h00, 8'h00, 1'b0);
    push_req(OP_LOAD, 8'h00, 8'hFF, 1'b1);
    push_req(OP_LOAD, 8'hFF, 8'h00, 1'b1);
    push_req(OP_READ, 8'hFF, 8'hFF, 1'b1);
    push_req(OP_READ, 8'h00, 8'h00, 1'b0);
    queue_edge_block();

    set_direction(1'b1);
    queue_edge_block();
    push_req(OP_LOAD, 8'h3C, 8'h01, 1'b0);
    push_req(OP_LOAD, 8'hC3, 8'hFE, 1'b1);
    push_req(OP_READ, 8'h00, 8'h00, 1'b0);
    push_req(OP_READ, 8'h00, 8'h00, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      set_direction(ph[0]);
      for (int half = 0; half < 2; half++) begin
        mark = n_queued;
        while (n_queued - mark < 55) begin
          if ($urandom_range(0, 5) == 0) queue_noise($urandom_range(1, 4));
          queue_block(($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) :
                      $urandom_range(1, 10), 1'b1);
        end
        if (ph == 1 && half == 1) queue_block(BLK_LIMIT, 1'b0);
        // sink holds off while requests keep coming
        if (ph == 0 && half == 0) hold_cmd++;
        wait_drained();
      end
    end

    repeat (20) @(negedge clk);
    if (shuffle_rsp_q.size() != 0) begin
      n_err++;
      $display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d",
               $time, shuffle_rsp_q.size(), shuffle_rsp_q.size());
    end
    $display({"Sent %0d requests: %0d loads stored, %0d loads refused busy, ",
              "%0d bytes read, %0d reads with nothing ready."},
             n_taken, n_load, n_busy, n_read, n_idle_rd);
    $display("Blocks permuted: %0d forward, %0d reverse, largest %0d bytes; %0d results checked.",
             n_fwd, n_rev, n_max, n_results);
    if (n_err == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pkbs_pkg.sv
rtl/core/pkbs_ram.sv
rtl/core/pad_keyed_byte_block_shuffle_unit.sv
rtl/core/pkbs_checker.sv
verif/testbench.sv
